// ----- rtl/pgf_pkg.sv -----
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared widths, payload types and constants for the pairwise gravity force
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pgf_pkg;

   // Field widths of the transfer payloads.
   localparam int POS_BITS   = 24;
   localparam int MASS_BITS  = 24;
   localparam int G_W        = 32;
   localparam int FLOOR_W    = 48;
   localparam int FORCE_W    = 32;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 1;

   // Derived datapath widths.
   localparam int DIFF_W     = POS_BITS + 1;
   localparam int MAG_W      = POS_BITS;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int R2_W       = (SQ_W + 1 > FLOOR_W) ? SQ_W + 1 : FLOOR_W;
   localparam int SQRT_STEPS = (R2_W + 1) / 2;
   localparam int RT_W       = SQRT_STEPS;
   localparam int SQ_STEP_W  = $clog2(SQRT_STEPS);
   localparam int GM_W       = G_W + MASS_BITS;
   localparam int PM_W       = MASS_BITS + MAG_W;
   localparam int NUM_W      = GM_W + PM_W;
   localparam int GM_LO_W    = GM_W / 2;
   localparam int GM_HI_W    = GM_W - GM_LO_W;
   localparam int PM_LO_W    = PM_W / 2;
   localparam int PM_HI_W    = PM_W - PM_LO_W;
   localparam int PP_W       = GM_HI_W + PM_HI_W;
   localparam int R2_LO_W    = R2_W / 2;
   localparam int R2_HI_W    = R2_W - R2_LO_W;
   localparam int DEN_SHIFT  = 16;
   localparam int DEN_W      = R2_W + RT_W + DEN_SHIFT;
   localparam int Q_W        = FORCE_W;
   localparam int DIV_STEP_W = $clog2(Q_W);
   localparam int CMP_W      = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_R2  = CSR_IDX_W'(1);

   // Register reset values: G = 1.0 and a floor of 100 square units.
   localparam logic [G_W-1:0]     GRAVITY_RESET = G_W'(32'd16777216);
   localparam logic [FLOOR_W-1:0] MIN_R2_RESET  = FLOOR_W'(48'd6553600);

   // Clipping limits of a force component, as magnitudes.
   localparam logic [FORCE_W-1:0] SAT_POS_MAG = {1'b0, {(FORCE_W-1){1'b1}}};
   localparam logic [FORCE_W-1:0] SAT_NEG_MAG = {1'b1, {(FORCE_W-1){1'b0}}};

   typedef struct packed {
      logic signed [POS_BITS-1:0] pos_a_x;
      logic signed [POS_BITS-1:0] pos_a_y;
      logic signed [POS_BITS-1:0] pos_b_x;
      logic signed [POS_BITS-1:0] pos_b_y;
      logic [MASS_BITS-1:0]       mass_a;
      logic [MASS_BITS-1:0]       mass_b;
   } pgf_req_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic                      softened;
      logic                      saturated;
   } pgf_rsp_type;

   // Working set that travels down the cell chains.
   typedef struct packed {
      logic              neg_x;
      logic              neg_y;
      logic              softened;
      logic              zero;
      logic [R2_W-1:0]   r2;
      logic [R2_W-1:0]   sq_rem;
      logic [R2_W-1:0]   root;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [DEN_W-1:0]  den;
      logic              over_x;
      logic              over_y;
      logic [Q_W-1:0]    q_x;
      logic [Q_W-1:0]    q_y;
   } pgf_work_type;

endpackage

`default_nettype wire

// ----- rtl/pgf_front.sv -----
// ----------------------------------------------------------------------------
// pgf_front
// Input register, displacement, squares, mass products and the wide
// numerators, ending in the working set for the square root chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              req_valid,
   input  pgf_pkg::pgf_req_type              req_data,
   input  logic [pgf_pkg::G_W-1:0]           gravity,
   input  logic [pgf_pkg::FLOOR_W-1:0]       min_r2,
   output logic                              work_valid,
   output pgf_pkg::pgf_work_type             work
);

   // Stage A: input register.
   logic                  a_vld_ff;
   pgf_pkg::pgf_req_type  a_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_req_ff <= req_data;
      end
   end

   // Stage B: displacement B minus A, split into sign and magnitude.
   logic [pgf_pkg::DIFF_W-1:0] dx_in, dy_in, ndx_in, ndy_in;
   logic [pgf_pkg::MAG_W-1:0]  b_mag_x_ff, b_mag_y_ff;
   logic                       b_neg_x_ff, b_neg_y_ff, b_vld_ff;
   logic [pgf_pkg::MASS_BITS-1:0] b_ma_ff, b_mb_ff;

   always_comb begin
      dx_in  = {a_req_ff.pos_b_x[pgf_pkg::POS_BITS-1], a_req_ff.pos_b_x}
             - {a_req_ff.pos_a_x[pgf_pkg::POS_BITS-1], a_req_ff.pos_a_x};
      dy_in  = {a_req_ff.pos_b_y[pgf_pkg::POS_BITS-1], a_req_ff.pos_b_y}
             - {a_req_ff.pos_a_y[pgf_pkg::POS_BITS-1], a_req_ff.pos_a_y};
      ndx_in = dx_in[pgf_pkg::DIFF_W-1] ? (~dx_in + pgf_pkg::DIFF_W'(1)) : dx_in;
      ndy_in = dy_in[pgf_pkg::DIFF_W-1] ? (~dy_in + pgf_pkg::DIFF_W'(1)) : dy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_neg_x_ff <= dx_in[pgf_pkg::DIFF_W-1];
         b_neg_y_ff <= dy_in[pgf_pkg::DIFF_W-1];
         b_mag_x_ff <= ndx_in[pgf_pkg::MAG_W-1:0];
         b_mag_y_ff <= ndy_in[pgf_pkg::MAG_W-1:0];
         b_ma_ff    <= a_req_ff.mass_a;
         b_mb_ff    <= a_req_ff.mass_b;
      end
   end

   // Stage C: squares, G times mass A, and mass B times each magnitude.
   logic                     c_vld_ff, c_neg_x_ff, c_neg_y_ff;
   logic [pgf_pkg::SQ_W-1:0] c_sx_ff, c_sy_ff;
   logic [pgf_pkg::GM_W-1:0] c_gm_ff;
   logic [pgf_pkg::PM_W-1:0] c_pmx_ff, c_pmy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_neg_x_ff <= b_neg_x_ff;
         c_neg_y_ff <= b_neg_y_ff;
         c_sx_ff    <= pgf_pkg::SQ_W'(b_mag_x_ff) * pgf_pkg::SQ_W'(b_mag_x_ff);
         c_sy_ff    <= pgf_pkg::SQ_W'(b_mag_y_ff) * pgf_pkg::SQ_W'(b_mag_y_ff);
         c_gm_ff    <= pgf_pkg::GM_W'(gravity) * pgf_pkg::GM_W'(b_ma_ff);
         c_pmx_ff   <= pgf_pkg::PM_W'(b_mb_ff) * pgf_pkg::PM_W'(b_mag_x_ff);
         c_pmy_ff   <= pgf_pkg::PM_W'(b_mb_ff) * pgf_pkg::PM_W'(b_mag_y_ff);
      end
   end

   // Stage D: floored squared distance and partial products of the numerators.
   logic [pgf_pkg::R2_W-1:0] r2_sum_in;
   logic                     soft_in;
   logic                     d_vld_ff, d_neg_x_ff, d_neg_y_ff, d_soft_ff;
   logic [pgf_pkg::R2_W-1:0] d_r2_ff;
   logic [pgf_pkg::PP_W-1:0] d_ppx_ff [4];
   logic [pgf_pkg::PP_W-1:0] d_ppy_ff [4];
   logic [pgf_pkg::GM_LO_W-1:0] gm_lo;
   logic [pgf_pkg::GM_HI_W-1:0] gm_hi;

   always_comb begin
      r2_sum_in = pgf_pkg::R2_W'(c_sx_ff) + pgf_pkg::R2_W'(c_sy_ff);
      soft_in   = r2_sum_in < pgf_pkg::R2_W'(min_r2);
      gm_lo     = c_gm_ff[pgf_pkg::GM_LO_W-1:0];
      gm_hi     = c_gm_ff[pgf_pkg::GM_W-1:pgf_pkg::GM_LO_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_neg_x_ff  <= c_neg_x_ff;
         d_neg_y_ff  <= c_neg_y_ff;
         d_soft_ff   <= soft_in;
         d_r2_ff     <= soft_in ? pgf_pkg::R2_W'(min_r2) : r2_sum_in;
         d_ppx_ff[0] <= pgf_pkg::PP_W'(gm_lo)
                      * pgf_pkg::PP_W'(c_pmx_ff[pgf_pkg::PM_LO_W-1:0]);
         d_ppx_ff[1] <= pgf_pkg::PP_W'(gm_lo)
                      * pgf_pkg::PP_W'(c_pmx_ff[pgf_pkg::PM_W-1:pgf_pkg::PM_LO_W]);
         d_ppx_ff[2] <= pgf_pkg::PP_W'(gm_hi)
                      * pgf_pkg::PP_W'(c_pmx_ff[pgf_pkg::PM_LO_W-1:0]);
         d_ppx_ff[3] <= pgf_pkg::PP_W'(gm_hi)
                      * pgf_pkg::PP_W'(c_pmx_ff[pgf_pkg::PM_W-1:pgf_pkg::PM_LO_W]);
         d_ppy_ff[0] <= pgf_pkg::PP_W'(gm_lo)
                      * pgf_pkg::PP_W'(c_pmy_ff[pgf_pkg::PM_LO_W-1:0]);
         d_ppy_ff[1] <= pgf_pkg::PP_W'(gm_lo)
                      * pgf_pkg::PP_W'(c_pmy_ff[pgf_pkg::PM_W-1:pgf_pkg::PM_LO_W]);
         d_ppy_ff[2] <= pgf_pkg::PP_W'(gm_hi)
                      * pgf_pkg::PP_W'(c_pmy_ff[pgf_pkg::PM_LO_W-1:0]);
         d_ppy_ff[3] <= pgf_pkg::PP_W'(gm_hi)
                      * pgf_pkg::PP_W'(c_pmy_ff[pgf_pkg::PM_W-1:pgf_pkg::PM_LO_W]);
      end
   end

   // Stage E: sum the partial products and seed the working set.
   logic                  e_vld_ff;
   pgf_pkg::pgf_work_type e_work_ff, e_work_in;

   always_comb begin
      e_work_in          = '0;
      e_work_in.neg_x    = d_neg_x_ff;
      e_work_in.neg_y    = d_neg_y_ff;
      e_work_in.softened = d_soft_ff;
      e_work_in.zero     = (d_r2_ff == '0);
      e_work_in.r2       = d_r2_ff;
      e_work_in.sq_rem   = d_r2_ff;
      e_work_in.num_x    = pgf_pkg::NUM_W'(d_ppx_ff[0])
                         + (pgf_pkg::NUM_W'(d_ppx_ff[1]) << pgf_pkg::PM_LO_W)
                         + (pgf_pkg::NUM_W'(d_ppx_ff[2]) << pgf_pkg::GM_LO_W)
                         + (pgf_pkg::NUM_W'(d_ppx_ff[3])
                            << (pgf_pkg::GM_LO_W + pgf_pkg::PM_LO_W));
      e_work_in.num_y    = pgf_pkg::NUM_W'(d_ppy_ff[0])
                         + (pgf_pkg::NUM_W'(d_ppy_ff[1]) << pgf_pkg::PM_LO_W)
                         + (pgf_pkg::NUM_W'(d_ppy_ff[2]) << pgf_pkg::GM_LO_W)
                         + (pgf_pkg::NUM_W'(d_ppy_ff[3])
                            << (pgf_pkg::GM_LO_W + pgf_pkg::PM_LO_W));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_work_ff <= e_work_in;
      end
   end

   assign work_valid = e_vld_ff;
   assign work       = e_work_ff;

endmodule

`default_nettype wire

// ----- rtl/pgf_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// pgf_sqrt_cell
// One digit step of the integer square root of the squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_sqrt_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic [pgf_pkg::SQ_STEP_W-1:0]   step,
   input  logic                            in_valid,
   input  pgf_pkg::pgf_work_type           in_work,
   output logic                            out_valid,
   output pgf_pkg::pgf_work_type           out_work
);

   logic [pgf_pkg::R2_W-1:0] bit_in, trial_in;
   pgf_pkg::pgf_work_type    work_in, work_ff;
   logic                     vld_ff;

   // Try the digit at this cell's bit pair; keep it when it fits.
   always_comb begin
      bit_in   = pgf_pkg::R2_W'(1) << {step, 1'b0};
      trial_in = in_work.root + bit_in;
      work_in  = in_work;
      if (in_work.sq_rem >= trial_in) begin
         work_in.sq_rem = in_work.sq_rem - trial_in;
         work_in.root   = (in_work.root >> 1) + bit_in;
      end else begin
         work_in.root   = in_work.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

// ----- rtl/pgf_den.sv -----
// ----------------------------------------------------------------------------
// pgf_den
// Builds the denominator r2 * r * 2^16 and flags quotients that cannot fit
// in the force width.
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_den (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  pgf_pkg::pgf_work_type  in_work,
   output logic                   out_valid,
   output pgf_pkg::pgf_work_type  out_work
);

   // Stage P: partial products of r2 and the root.
   logic                                            p_vld_ff;
   pgf_pkg::pgf_work_type                           p_work_ff;
   logic [pgf_pkg::R2_LO_W+pgf_pkg::RT_W-1:0]       p_lo_ff;
   logic [pgf_pkg::R2_HI_W+pgf_pkg::RT_W-1:0]       p_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_work_ff <= in_work;
         p_lo_ff   <= (pgf_pkg::R2_LO_W + pgf_pkg::RT_W)'(in_work.r2[pgf_pkg::R2_LO_W-1:0])
                    * (pgf_pkg::R2_LO_W + pgf_pkg::RT_W)'(in_work.root[pgf_pkg::RT_W-1:0]);
         p_hi_ff   <= (pgf_pkg::R2_HI_W + pgf_pkg::RT_W)'
                         (in_work.r2[pgf_pkg::R2_W-1:pgf_pkg::R2_LO_W])
                    * (pgf_pkg::R2_HI_W + pgf_pkg::RT_W)'(in_work.root[pgf_pkg::RT_W-1:0]);
      end
   end

   // Stage Q: combine the partial products and scale by 2^16.
   logic                  q_vld_ff;
   pgf_pkg::pgf_work_type q_work_ff, q_work_in;

   always_comb begin
      q_work_in     = p_work_ff;
      q_work_in.den = ((pgf_pkg::DEN_W'(p_hi_ff) << pgf_pkg::R2_LO_W)
                      + pgf_pkg::DEN_W'(p_lo_ff)) << pgf_pkg::DEN_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (en) begin
         q_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_work_ff <= q_work_in;
      end
   end

   // Stage R: a numerator at or above den * 2^32 clips regardless of sign.
   logic                     r_vld_ff;
   pgf_pkg::pgf_work_type    r_work_ff, r_work_in;
   logic [pgf_pkg::CMP_W-1:0] den_top;

   always_comb begin
      den_top          = pgf_pkg::CMP_W'(q_work_ff.den) << pgf_pkg::Q_W;
      r_work_in        = q_work_ff;
      r_work_in.over_x = pgf_pkg::CMP_W'(q_work_ff.num_x) >= den_top;
      r_work_in.over_y = pgf_pkg::CMP_W'(q_work_ff.num_y) >= den_top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (en) begin
         r_vld_ff <= q_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_work_ff <= r_work_in;
      end
   end

   assign out_valid = r_vld_ff;
   assign out_work  = r_work_ff;

endmodule

`default_nettype wire

// ----- rtl/pgf_div_cell.sv -----
// ----------------------------------------------------------------------------
// pgf_div_cell
// One restoring division step for both force components.
// ----------------------------------------------------------------------------
`default_nettype none

module pgf_div_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic [pgf_pkg::DIV_STEP_W-1:0]   step,
   input  logic                             in_valid,
   input  pgf_pkg::pgf_work_type            in_work,
   output logic                             out_valid,
   output pgf_pkg::pgf_work_type            out_work
);

   logic [pgf_pkg::CMP_W-1:0] shifted;
   logic                      ge_x, ge_y;
   pgf_pkg::pgf_work_type     work_in, work_ff;
   logic                      vld_ff;

   // The remainder lives in the numerator fields; one quotient bit per cell.
   always_comb begin
      shifted       = pgf_pkg::CMP_W'(in_work.den) << step;
      ge_x          = pgf_pkg::CMP_W'(in_work.num_x) >= shifted;
      ge_y          = pgf_pkg::CMP_W'(in_work.num_y) >= shifted;
      work_in       = in_work;
      work_in.num_x = ge_x ? in_work.num_x - shifted[pgf_pkg::NUM_W-1:0] : in_work.num_x;
      work_in.num_y = ge_y ? in_work.num_y - shifted[pgf_pkg::NUM_W-1:0] : in_work.num_y;
      work_in.q_x   = {in_work.q_x[pgf_pkg::Q_W-2:0], ge_x};
      work_in.q_y   = {in_work.q_y[pgf_pkg::Q_W-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_work  = work_ff;

endmodule

`default_nettype wire

// ----- rtl/pairwise_gravity_force_top.sv -----
// ----------------------------------------------------------------------------
// pairwise_gravity_force_top
// Softened 2D gravity force of B on A, one body pair per clock unless stalled.
//
// The req_ channel carries both positions and both masses; the rsp_ channel
// returns force_x, force_y (signed Q24.8, clipped), softened and saturated.
// A transfer happens on a rising edge with valid high and stall low.
// The csr_ port writes G (index 0) and the squared distance floor (index 1)
// and the user must use it only while the pipeline is empty; nothing enforces it.
// An accepted request passes through five front stages, 25 square root cells
// (one per root bit), three denominator stages, 32 division cells (one per
// quotient bit) and the output register.
// Throughput is one pair per cycle unless stalled; each stage holds one pair.
// When the receiver stalls a valid result, the whole pipeline holds and
// req_stall rises in the same cycle; it falls as soon as the result leaves.
// A synchronous reset empties the pipeline and restores G to 1.0 and the
// floor to 100 square units.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_gravity_force_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pgf_pkg::pgf_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pgf_pkg::pgf_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic [pgf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pgf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers.
   logic [pgf_pkg::G_W-1:0]     gravity_ff;
   logic [pgf_pkg::FLOOR_W-1:0] min_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= pgf_pkg::GRAVITY_RESET;
         min_r2_ff  <= pgf_pkg::MIN_R2_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pgf_pkg::CSR_GRAVITY: begin
               gravity_ff <= csr_wdata[pgf_pkg::G_W-1:0];
            end
            pgf_pkg::CSR_MIN_R2: begin
               min_r2_ff <= csr_wdata[pgf_pkg::FLOOR_W-1:0];
            end
            default: begin
               gravity_ff <= gravity_ff;
            end
         endcase
      end
   end

   // The pipeline advances unless a finished result is held up.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Front stages.
   logic                  front_vld;
   pgf_pkg::pgf_work_type front_work;

   pgf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .gravity    (gravity_ff),
      .min_r2     (min_r2_ff),
      .work_valid (front_vld),
      .work       (front_work)
   );

   // Square root chain, most significant bit pair first.
   logic                  sq_vld  [pgf_pkg::SQRT_STEPS+1];
   pgf_pkg::pgf_work_type sq_work [pgf_pkg::SQRT_STEPS+1];

   assign sq_vld[0]  = front_vld;
   assign sq_work[0] = front_work;

   for (genvar i = 0; i < pgf_pkg::SQRT_STEPS; i++) begin : g_sqrt
      pgf_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (pgf_pkg::SQ_STEP_W'(pgf_pkg::SQRT_STEPS - 1 - i)),
         .in_valid  (sq_vld[i]),
         .in_work   (sq_work[i]),
         .out_valid (sq_vld[i+1]),
         .out_work  (sq_work[i+1])
      );
   end

   // Denominator and overflow screening.
   logic                  den_vld;
   pgf_pkg::pgf_work_type den_work;

   pgf_den u_den (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld[pgf_pkg::SQRT_STEPS]),
      .in_work   (sq_work[pgf_pkg::SQRT_STEPS]),
      .out_valid (den_vld),
      .out_work  (den_work)
   );

   // Division chain, most significant quotient bit first.
   logic                  dv_vld  [pgf_pkg::Q_W+1];
   pgf_pkg::pgf_work_type dv_work [pgf_pkg::Q_W+1];

   assign dv_vld[0]  = den_vld;
   assign dv_work[0] = den_work;

   for (genvar j = 0; j < pgf_pkg::Q_W; j++) begin : g_div
      pgf_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (pgf_pkg::DIV_STEP_W'(pgf_pkg::Q_W - 1 - j)),
         .in_valid  (dv_vld[j]),
         .in_work   (dv_work[j]),
         .out_valid (dv_vld[j+1]),
         .out_work  (dv_work[j+1])
      );
   end

   // Clip, apply the sign and handle the zero distance case.
   pgf_pkg::pgf_work_type        fin;
   logic [pgf_pkg::FORCE_W-1:0]  lim_x, lim_y, mag_x, mag_y;
   logic                         clip_x, clip_y;
   pgf_pkg::pgf_rsp_type         rsp_in, rsp_ff;
   logic                         rsp_vld_ff;

   always_comb begin
      fin    = dv_work[pgf_pkg::Q_W];
      lim_x  = fin.neg_x ? pgf_pkg::SAT_NEG_MAG : pgf_pkg::SAT_POS_MAG;
      lim_y  = fin.neg_y ? pgf_pkg::SAT_NEG_MAG : pgf_pkg::SAT_POS_MAG;
      clip_x = !fin.zero && (fin.over_x || (fin.q_x > lim_x));
      clip_y = !fin.zero && (fin.over_y || (fin.q_y > lim_y));
      mag_x  = fin.zero ? '0 : (clip_x ? lim_x : fin.q_x);
      mag_y  = fin.zero ? '0 : (clip_y ? lim_y : fin.q_y);
      rsp_in.force_x   = fin.neg_x ? (~mag_x + pgf_pkg::FORCE_W'(1)) : mag_x;
      rsp_in.force_y   = fin.neg_y ? (~mag_y + pgf_pkg::FORCE_W'(1)) : mag_y;
      rsp_in.softened  = fin.softened;
      rsp_in.saturated = clip_x || clip_y;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_vld[pgf_pkg::Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- test/tb_pairwise_gravity_force_top.sv -----
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_force_top
// Self-checking bench for the pairwise softened gravity force pipeline.
//
// A directed table covers the extremes of the fields and the zero-distance,
// zero-mass and clipping cases. Random body pairs follow under several
// register settings. Each accepted transfer is predicted from an exact wide
// integer force model or given by the table, and results are checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pairwise_gravity_force_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 66;

   typedef struct {
      pgf_pkg::pgf_req_type pair;
      bit                   known;
      pgf_pkg::pgf_rsp_type force_ref;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   pgf_pkg::pgf_req_type           req_data;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   pgf_pkg::pgf_rsp_type           rsp_data;
   logic                           csr_we;
   logic [pgf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pgf_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Register copies used by the force predictor.
   logic [pgf_pkg::G_W-1:0]     grav_now;
   logic [pgf_pkg::FLOOR_W-1:0] floor_now;

   pgf_pkg::pgf_rsp_type force_expect_q[$];
   stim_row_type         stim_table[$];
   int                   fail_count;
   int                   cycle_count = 0;

   pairwise_gravity_force_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Integer square root, rounded down.
   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // One force component: truncated quotient, clipped, sign of d applied.
   function automatic logic [pgf_pkg::FORCE_W-1:0] force_part(logic [63:0] gm,
         longint d, logic [63:0] mb, logic [127:0] den, ref bit clipped);
      logic [63:0]  mag;
      logic [127:0] num;
      logic [127:0] q;
      logic [127:0] limit;
      logic [63:0]  m;
      mag   = (d < 0) ? 64'(-d) : 64'(d);
      limit = (d < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
      num   = 128'(gm) * 128'(mb * mag);
      q     = num / den;
      if (q > limit) begin
         q       = limit;
         clipped = 1'b1;
      end
      m = q[63:0];
      if (d < 0) m = -m;
      return m[pgf_pkg::FORCE_W-1:0];
   endfunction

   // Expected force of body B on body A under the current registers.
   function automatic pgf_pkg::pgf_rsp_type gravity_force(pgf_pkg::pgf_req_type p);
      pgf_pkg::pgf_rsp_type f;
      longint               dx;
      longint               dy;
      logic [63:0]          r2;
      logic [63:0]          rt;
      logic [127:0]         den;
      bit                   clipped;
      dx = longint'(p.pos_b_x) - longint'(p.pos_a_x);
      dy = longint'(p.pos_b_y) - longint'(p.pos_a_y);
      r2 = 64'(dx * dx) + 64'(dy * dy);
      f  = '0;
      clipped = 1'b0;
      if (r2 < 64'(floor_now)) begin
         r2 = 64'(floor_now);
         f.softened = 1'b1;
      end
      if (r2 != 0) begin
         rt  = root_floor(r2);
         den = (128'(r2) * 128'(rt)) << 16;
         f.force_x = force_part(64'(grav_now) * 64'(p.mass_a), dx, 64'(p.mass_b),
                                den, clipped);
         f.force_y = force_part(64'(grav_now) * 64'(p.mass_a), dy, 64'(p.mass_b),
                                den, clipped);
      end
      f.saturated = clipped;
      return f;
   endfunction

   function automatic stim_row_type stim_row(int ax, int ay, int bx, int by,
         int ma, int mb, bit known, int fx, int fy, bit floored, bit sat);
      stim_row_type r;
      r.pair = '{pos_a_x: ax[pgf_pkg::POS_BITS-1:0], pos_a_y: ay[pgf_pkg::POS_BITS-1:0],
                 pos_b_x: bx[pgf_pkg::POS_BITS-1:0], pos_b_y: by[pgf_pkg::POS_BITS-1:0],
                 mass_a: ma[pgf_pkg::MASS_BITS-1:0], mass_b: mb[pgf_pkg::MASS_BITS-1:0]};
      r.known = known;
      r.force_ref = '{force_x: fx, force_y: fy, softened: floored, saturated: sat};
      return r;
   endfunction

   function automatic pgf_pkg::pgf_req_type random_pair();
      pgf_pkg::pgf_req_type p;
      p = pgf_pkg::pgf_req_type'($bits(pgf_pkg::pgf_req_type)'(
             {$urandom, $urandom, $urandom, $urandom, $urandom}));
      // Most pairs are close together so that the floor and clipping matter.
      if ($urandom_range(0, 3) != 0) begin
         p.pos_b_x = p.pos_a_x + pgf_pkg::POS_BITS'($urandom_range(0, 8191))
                   - pgf_pkg::POS_BITS'(4096);
         p.pos_b_y = p.pos_a_y + pgf_pkg::POS_BITS'($urandom_range(0, 8191))
                   - pgf_pkg::POS_BITS'(4096);
      end
      if ($urandom_range(0, 15) == 0) p.mass_a = '0;
      if ($urandom_range(0, 15) == 0) p.pos_b_x = p.pos_a_x;
      return p;
   endfunction

   // One request transfer; valid stays high for a following item.
   task automatic send_pair(pgf_pkg::pgf_req_type p, bit known, pgf_pkg::pgf_rsp_type f);
      pgf_pkg::pgf_rsp_type exp_f;
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      exp_f = known ? f : gravity_force(p);
      force_expect_q = {force_expect_q, exp_f};
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (force_expect_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic reg_write(logic [pgf_pkg::CSR_IDX_W-1:0] idx,
                            logic [pgf_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == pgf_pkg::CSR_GRAVITY) grav_now = val[pgf_pkg::G_W-1:0];
      else floor_now = val[pgf_pkg::FLOOR_W-1:0];
      @(posedge clock);
   endtask

   // Random burst traffic; in half the runs, one long pause midway until the pipeline is empty.
   task automatic random_phase(int count);
      int burst;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
         end
         if (i == count / 2 && $urandom_range(0, 1) == 0) begin
            req_valid <= 1'b0;
            while (force_expect_q.size() != 0) @(posedge clock);
         end
         send_pair(random_pair(), 1'b0, '0);
         burst--;
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      pgf_pkg::pgf_rsp_type exp_f;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (force_expect_q.size() == 0) begin
            $error("unexpected result transfer %h", rsp_data);
            fail_count++;
         end else begin
            exp_f = force_expect_q.pop_front();
            if (rsp_data.force_x !== exp_f.force_x) begin
               $error("force_x expected %h actual %h", exp_f.force_x, rsp_data.force_x);
               fail_count++;
            end
            if (rsp_data.force_y !== exp_f.force_y) begin
               $error("force_y expected %h actual %h", exp_f.force_y, rsp_data.force_y);
               fail_count++;
            end
            if (rsp_data.softened !== exp_f.softened) begin
               $error("softened expected %b actual %b", exp_f.softened, rsp_data.softened);
               fail_count++;
            end
            if (rsp_data.saturated !== exp_f.saturated) begin
               $error("saturated expected %b actual %b", exp_f.saturated,
                      rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

   // Receiver stall pattern: calm, random and bursty stretches, plus one long hold.
   always @(posedge clock) begin
      int mode;
      cycle_count <= cycle_count + 1;
      mode = (cycle_count / 500) % 3;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (cycle_count >= 3000 && cycle_count < 3300) begin
         rsp_stall <= 1'b1;
      end else if (mode == 0) begin
         rsp_stall <= 1'b0;
      end else if (mode == 1) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= ((cycle_count % 16) < 6);
      end
   end

   initial begin
      #2ms;
      $display("tb_pairwise_gravity_force_top NOT OK");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = pgf_pkg::CSR_GRAVITY;
      csr_wdata   = '0;
      fail_count  = 0;
      grav_now    = pgf_pkg::GRAVITY_RESET;
      floor_now   = pgf_pkg::MIN_R2_RESET;

      // Directed rows under the reset registers.
      stim_table = {stim_table, stim_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0)};
      stim_table = {stim_table, stim_row(-8388608, -8388608, 8388607, 8388607, 0,
                                         16777215, 1, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(0, 0, 2560, 0, 16777215, 16777215,
                                         1, 32'h7FFF_FFFF, 0, 0, 1)};
      stim_table = {stim_table, stim_row(0, 0, -2560, 0, 16777215, 16777215,
                                         1, 32'h8000_0000, 0, 0, 1)};
      stim_table = {stim_table, stim_row(100, 100, 100, 2660, 16777215, 16777215,
                                         1, 0, 32'h7FFF_FFFF, 0, 1)};
      stim_table = {stim_table, stim_row(100, 100, 100, -2460, 16777215, 16777215,
                                         1, 0, 32'h8000_0000, 0, 1)};
      stim_table = {stim_table, stim_row(-8388608, -8388608, 8388607, 8388607,
                                         16777215, 16777215, 0, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(8388607, 8388607, -8388608, -8388608,
                                         16777215, 16777215, 0, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(8388607, -8388608, -8388608, 8388607,
                                         1, 1, 0, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(0, 0, 1, 0, 65536, 65536, 0, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(0, 0, 2559, 1, 16777215, 256, 0, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(-5, 7, 2000, -3000, 2560, 25600,
                                         0, 0, 0, 0, 0)};
      stim_table = {stim_table, stim_row(0, 0, 0, 0, 16777215, 16777215,
                                         1, 0, 0, 1, 0)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         send_pair(stim_table[i].pair, stim_table[i].known, stim_table[i].force_ref);
         if (i % 4 == 3) idle_gap($urandom_range(1, 3));
      end
      random_phase(400);
      drain();

      // Strongest G and no floor: zero distance yields zero force.
      reg_write(pgf_pkg::CSR_GRAVITY, pgf_pkg::CSR_DATA_W'(32'hFFFF_FFFF));
      reg_write(pgf_pkg::CSR_MIN_R2, '0);
      send_pair('{pos_a_x: 5, pos_a_y: -9, pos_b_x: 5, pos_b_y: -9,
                  mass_a: '1, mass_b: '1}, 1'b1, '0);
      random_phase(350);
      drain();

      // Zero G and the largest floor.
      reg_write(pgf_pkg::CSR_GRAVITY, '0);
      reg_write(pgf_pkg::CSR_MIN_R2, {pgf_pkg::FLOOR_W{1'b1}});
      random_phase(150);
      drain();

      // Small G with the largest floor, then random settings.
      reg_write(pgf_pkg::CSR_GRAVITY, pgf_pkg::CSR_DATA_W'(32'd1));
      random_phase(150);
      drain();
      for (int k = 0; k < 3; k++) begin
         reg_write(pgf_pkg::CSR_GRAVITY, pgf_pkg::CSR_DATA_W'($urandom));
         reg_write(pgf_pkg::CSR_MIN_R2,
                   pgf_pkg::CSR_DATA_W'($urandom_range(0, 1 << 26)));
         random_phase(250);
         drain();
      end

      if (fail_count == 0) begin
         $display("tb_pairwise_gravity_force_top OK");
      end else begin
         $display("tb_pairwise_gravity_force_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
